// ----- sv/epfr_pkg.sv -----
// shared constants, types and helpers of the event pixel fan-out remapper
package epfr_pkg;

   // table geometry
   localparam int PIXELS     = 65536;
   localparam int MAX_FANOUT = 4;

   localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int CNT_W   = $clog2(MAX_FANOUT + 1);
   localparam int DEST_AW = $clog2(PIXELS * MAX_FANOUT);

   // field widths
   localparam int OP_W      = 2;
   localparam int COORD_W   = 10;
   localparam int WORD_W    = 32;
   localparam int FLAT_W    = 16;
   localparam int DIM_W     = 11;
   localparam int AREA_W    = 21;
   localparam int DIM_MAX   = 1024;
   localparam int DIM_RESET = 256;
   localparam int DIV_CNT_W = $clog2(FLAT_W + 1);

   // stream payload widths
   localparam int IN_DATA_W  = 120;
   localparam int OUT_DATA_W = 88;

   // register file
   localparam int REG_IDX_W = 8;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = REG_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_EVENT = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_EVENT  = 1'b1
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       src_ravel;
      logic       cnt_rd;
      logic       div_start;
      logic       ld_commit;
      logic       clr_wr;
      logic       slot_first;
      logic       slot_next;
      logic       out_load;
      kind_type   out_kind;
      status_type out_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ld_bad;
      logic ev_bad;
      logic src_big;
      logic cnt_full;
      logic cnt_zero;
      logic div_done;
      logic clr_last;
      logic slot_last;
      logic out_free;
   } sts_type;

   // sensor dimension limited to 1..DIM_MAX
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(DIM_MAX)) begin
         r = DIM_W'(DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- sv/epfr_divider.sv -----
// restoring divider, one quotient bit per cycle, splits a flat index by the row width
module epfr_divider
   import epfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FLAT_W-1:0]  dividend,
   input  logic [DIM_W-1:0]   divisor,
   output logic               done,
   output logic [FLAT_W-1:0]  quotient,
   output logic [COORD_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [FLAT_W-1:0]    quo_ff, quo_in;
   logic [DIM_W:0]       trial;
   logic                 step_last;

   // one shift and trial subtract per step
   always_comb begin
      trial     = {rem_ff, quo_ff[FLAT_W-1]};
      step_last = (cnt_ff == DIV_CNT_W'(FLAT_W - 1));
      busy_in   = busy_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         cnt_in = DIV_CNT_W'(cnt_ff + DIV_CNT_W'(1));
         if (trial >= {1'b0, divisor}) begin
            rem_in = DIM_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[FLAT_W-2:0], 1'b1};
         end else begin
            rem_in = DIM_W'(trial);
            quo_in = {quo_ff[FLAT_W-2:0], 1'b0};
         end
         if (step_last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = COORD_W'(rem_ff);

endmodule

// ----- sv/epfr_datapath.sv -----
// datapath: item registers, sensor registers, fan-out tables and result register
module epfr_datapath
   import epfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   // input item fields
   input  logic [COORD_W-1:0]   req_event_x,
   input  logic [COORD_W-1:0]   req_event_y,
   input  logic [WORD_W-1:0]    req_timestamp,
   input  logic [WORD_W-1:0]    req_polarity,
   input  logic [FLAT_W-1:0]    req_src_index,
   input  logic [FLAT_W-1:0]    req_dst_index,
   // register writes
   input  logic                 csr_write,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data,
   // result register
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output kind_type             rsp_kind,
   output status_type           rsp_status,
   output logic [COORD_W-1:0]   rsp_out_x,
   output logic [COORD_W-1:0]   rsp_out_y,
   output logic [WORD_W-1:0]    rsp_out_timestamp,
   output logic [WORD_W-1:0]    rsp_out_polarity,
   output logic                 rsp_last
);

   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [AREA_W-1:0]    area_ff;
   logic [COORD_W-1:0]   x_ff, y_ff;
   logic [WORD_W-1:0]    ts_ff, pol_ff;
   logic [FLAT_W-1:0]    dst_ff;
   logic [AREA_W-1:0]    src_ff;
   logic [PIX_W-1:0]     clr_addr_ff;
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic [CNT_W-1:0]     slot_ff;
   logic [2*COORD_W-1:0] dest_rd_ff;
   logic                 rsp_valid_ff;
   kind_type             rsp_kind_ff;
   status_type           rsp_status_ff;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [WORD_W-1:0]    rsp_ts_ff, rsp_pol_ff;
   logic                 rsp_last_ff;

   logic [CNT_W-1:0]     cnt_mem [PIXELS];
   logic [2*COORD_W-1:0] dest_mem [PIXELS * MAX_FANOUT];

   logic [PIX_W-1:0]     src_idx;
   logic [DEST_AW-1:0]   dest_base;
   logic [CNT_W-1:0]     rd_slot;
   logic [CNT_W-1:0]     fan_n;
   logic [CNT_W-1:0]     slot_plus;
   logic                 div_done;
   logic [FLAT_W-1:0]    div_quo;
   logic [COORD_W-1:0]   div_rem;

   // sensor registers, stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(DIM_RESET);
         height_ff <= DIM_W'(DIM_RESET);
      end else if (csr_write) begin
         if (csr_index == REG_WIDTH) begin
            width_ff <= clamp_dim(csr_data);
         end else if (csr_index == REG_HEIGHT) begin
            height_ff <= clamp_dim(csr_data);
         end
      end
   end

   // sensor area is registered from the sensor registers, following them in the next cycle
   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(width_ff) * AREA_W'(height_ff);
   end

   // item capture and ravel of the event coordinates
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= req_event_x;
         y_ff   <= req_event_y;
         ts_ff  <= req_timestamp;
         pol_ff <= req_polarity;
         dst_ff <= req_dst_index;
         src_ff <= AREA_W'(req_src_index);
      end else if (cmd.src_ravel) begin
         src_ff <= AREA_W'(y_ff) * AREA_W'(width_ff) + AREA_W'(x_ff);
      end
   end

   // destination split into column and row
   epfr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dst_ff),
      .divisor   (width_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // table addressing
   always_comb begin
      src_idx   = src_ff[PIX_W-1:0];
      dest_base = DEST_AW'(src_idx) * DEST_AW'(MAX_FANOUT);
      slot_plus = CNT_W'(slot_ff + CNT_W'(1));
      rd_slot   = cmd.slot_first ? '0 : slot_plus;
      fan_n     = (cnt_rd_ff > CNT_W'(MAX_FANOUT)) ? CNT_W'(MAX_FANOUT) : cnt_rd_ff;
   end

   // sweep address of the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         if (clr_addr_ff == PIX_W'(PIXELS - 1)) begin
            clr_addr_ff <= '0;
         end else begin
            clr_addr_ff <= PIX_W'(clr_addr_ff + PIX_W'(1));
         end
      end
   end

   // fan-out count memory
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         cnt_mem[clr_addr_ff] <= '0;
      end else if (cmd.ld_commit) begin
         cnt_mem[src_idx] <= CNT_W'(cnt_rd_ff + CNT_W'(1));
      end
      if (cmd.cnt_rd) begin
         cnt_rd_ff <= cnt_mem[src_idx];
      end
   end

   // destination memory, row in the upper half, column in the lower
   always_ff @(posedge clock) begin
      if (cmd.ld_commit) begin
         dest_mem[dest_base + DEST_AW'(cnt_rd_ff)] <= {div_quo[COORD_W-1:0], div_rem};
      end
      if (cmd.slot_first || cmd.slot_next) begin
         dest_rd_ff <= dest_mem[dest_base + DEST_AW'(rd_slot)];
         slot_ff    <= rd_slot;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff   <= cmd.out_kind;
         rsp_status_ff <= cmd.out_status;
         if (cmd.out_kind == KIND_EVENT) begin
            rsp_x_ff    <= dest_rd_ff[COORD_W-1:0];
            rsp_y_ff    <= dest_rd_ff[2*COORD_W-1:COORD_W];
            rsp_ts_ff   <= ts_ff;
            rsp_pol_ff  <= pol_ff;
            rsp_last_ff <= (slot_plus == fan_n);
         end else begin
            rsp_x_ff    <= '0;
            rsp_y_ff    <= '0;
            rsp_ts_ff   <= '0;
            rsp_pol_ff  <= '0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   // status toward the controller
   always_comb begin
      sts.ld_bad    = (src_ff >= area_ff) || (AREA_W'(dst_ff) >= area_ff)
                      || (src_ff >= AREA_W'(PIXELS));
      sts.ev_bad    = ({1'b0, x_ff} >= width_ff) || ({1'b0, y_ff} >= height_ff);
      sts.src_big   = (src_ff >= AREA_W'(PIXELS));
      sts.cnt_full  = (cnt_rd_ff >= CNT_W'(MAX_FANOUT));
      sts.cnt_zero  = (cnt_rd_ff == '0);
      sts.div_done  = div_done;
      sts.clr_last  = (clr_addr_ff == PIX_W'(PIXELS - 1));
      sts.slot_last = (slot_plus == fan_n);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_timestamp = rsp_ts_ff;
   assign rsp_out_polarity  = rsp_pol_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- sv/epfr_ctrl.sv -----
// controller: sequences loads, events, table clears and result transfers
module epfr_ctrl
   import epfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_tready,
   input  sts_type         sts,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LD_CHECK,
      ST_LD_WAIT,
      ST_EV_CHECK,
      ST_EV_SRC,
      ST_EV_CNT,
      ST_EV_EMIT,
      ST_STATUS
   } state_type;

   state_type  state_ff, state_in;
   logic       reply_ff, reply_in;
   status_type status_ff, status_in;

   // next state and commands
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      reply_in   = reply_ff;
      status_in  = status_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               reply_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = reply_ff ? ST_STATUS : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (op_type'(req_op))
                  OP_LOAD:  state_in = ST_LD_CHECK;
                  OP_EVENT: state_in = ST_EV_CHECK;
                  OP_CLEAR: begin
                     reply_in = 1'b1;
                     state_in = ST_SWEEP;
                  end
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_CHECK: begin
            if (sts.ld_bad) begin
               status_in = STATUS_RANGE;
               state_in  = ST_STATUS;
            end else begin
               cmd.cnt_rd    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_LD_WAIT;
            end
         end
         ST_LD_WAIT: begin
            if (sts.cnt_full) begin
               status_in = STATUS_FULL;
               state_in  = ST_STATUS;
            end else if (sts.div_done) begin
               cmd.ld_commit = 1'b1;
               status_in     = STATUS_OK;
               state_in      = ST_STATUS;
            end
         end
         ST_EV_CHECK: begin
            if (sts.ev_bad) begin
               state_in = ST_IDLE;
            end else begin
               cmd.src_ravel = 1'b1;
               state_in      = ST_EV_SRC;
            end
         end
         ST_EV_SRC: begin
            if (sts.src_big) begin
               state_in = ST_IDLE;
            end else begin
               cmd.cnt_rd = 1'b1;
               state_in   = ST_EV_CNT;
            end
         end
         ST_EV_CNT: begin
            if (sts.cnt_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.slot_first = 1'b1;
               state_in       = ST_EV_EMIT;
            end
         end
         ST_EV_EMIT: begin
            // one destination per cycle while the result register drains
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_EVENT;
               cmd.out_status = STATUS_OK;
               if (sts.slot_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.slot_next = 1'b1;
               end
            end
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_STATUS;
               cmd.out_status = status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         reply_ff  <= 1'b0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         reply_ff  <= reply_in;
         status_ff <= status_in;
      end
   end

endmodule

// ----- sv/event_pixel_fanout_remapper_core.sv -----
// top level of the event pixel fan-out remapper
//
// Usage: items arrive on the req_ stream, op in req_tuser. A load adds one source to
// destination pair and answers one status transfer; a clear empties the table and
// answers one status transfer; an event answers one transfer per stored destination,
// tlast on the final one, and nothing when the pixel is unmapped or off the sensor.
// Op code 3 is taken and dropped. The csr_ channel writes the sensor width (index 0)
// and height (index 1) and is always ready; write it only while the block is idle.
// Timing: one item is worked on at a time and req_tready is high only between items.
// A load waits for the 16-step divider that splits the destination into column and row.
// An event first ravels its pixel and reads the count, then emits its destinations
// in turn, each one as the result register has room.
// A clear, and reset, run a clearing pass over the 65536 entries of the count memory
// (one entry a cycle) during which no item is taken.
// The result register sits between the sides: a new item is taken while a result
// waits; a stalled receiver holds the result and stops further results.
module event_pixel_fanout_remapper_core
   import epfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // event_x, event_y, timestamp, polarity, src_index, dst_index
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // op
   input  logic [OP_W-1:0]       req_tuser,
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, out_x, out_y, out_timestamp, out_polarity
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // kind
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

   cmd_type            cmd;
   sts_type            sts;
   kind_type           rsp_kind;
   status_type         rsp_status;
   logic [COORD_W-1:0] rsp_out_x, rsp_out_y;
   logic [WORD_W-1:0]  rsp_out_timestamp, rsp_out_polarity;

   assign csr_ready = 1'b1;

   // sequencing
   epfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and arithmetic
   epfr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_event_x       (req_tdata[9:0]),
      .req_event_y       (req_tdata[19:10]),
      .req_timestamp     (req_tdata[51:20]),
      .req_polarity      (req_tdata[83:52]),
      .req_src_index     (req_tdata[99:84]),
      .req_dst_index     (req_tdata[115:100]),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_timestamp (rsp_out_timestamp),
      .rsp_out_polarity  (rsp_out_polarity),
      .rsp_last          (rsp_tlast)
   );

   // result packing, status in the lowest bits
   assign rsp_tdata = {2'b00, rsp_out_polarity, rsp_out_timestamp, rsp_out_y, rsp_out_x,
                       rsp_status};
   assign rsp_tuser = rsp_kind;

   // a result is only loaded when the register is free or being drained
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a pending transfer");

   // a pair is stored only into a non-full entry once the split is finished
   a_commit_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_commit |-> (sts.div_done && !sts.cnt_full))
      else $error("load committed early or into a full entry");

   // the clearing pass keeps the input closed right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during clearing pass");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the event pixel fan-out remapper: table loads, event fan-out, clears
`timescale 1ns / 1ps

module tb_top
   import epfr_pkg::*;
();

   localparam int STALL_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(2);

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [WORD_W-1:0]  ts;
      logic [WORD_W-1:0]  pol;
      logic [FLAT_W-1:0]  src;
      logic [FLAT_W-1:0]  dst;
      bit                 hold;
   } pixel_item_type;

   typedef struct {
      kind_type           kind;
      status_type         status;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [WORD_W-1:0]  ts;
      logic [WORD_W-1:0]  pol;
      logic               last;
   } remap_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [REG_IDX_W-1:0]  csr_index  = '0;
   logic [DIM_W-1:0]      csr_data   = '0;

   always #2 clock = ~clock;

   event_pixel_fanout_remapper_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // shadow of the sensor size and the fan-out table
   logic [DIM_W-1:0]   shadow_width  = DIM_W'(DIM_RESET);
   logic [DIM_W-1:0]   shadow_height = DIM_W'(DIM_RESET);
   logic [CNT_W-1:0]   fanout_seen [int];
   logic [COORD_W-1:0] dest_x_seen [int];
   logic [COORD_W-1:0] dest_y_seen [int];

   pixel_item_type   item_backlog [$];
   remap_result_type results_due [$];

   int  n_queued    = 0;
   int  n_accepted  = 0;
   int  n_predicted = 0;
   int  n_checked   = 0;
   int  n_errors    = 0;
   int  n_loads     = 0;
   int  n_events    = 0;
   int  n_clears    = 0;
   int  n_unused    = 0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   int  idle_cycles = 0;
   bit  quiet       = 1'b0;

   // sensor dimension as the block uses it
   function automatic int sensor_dim(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > DIM_W'(DIM_MAX)) return DIM_MAX;
      return int'(v);
   endfunction

   // apply one item to the shadow table and queue the results it causes
   function int remap_item(input pixel_item_type it);
      int w, h, area, src, dst, cnt, k;
      remap_result_type r;
      w    = sensor_dim(shadow_width);
      h    = sensor_dim(shadow_height);
      area = w * h;
      cnt  = 0;
      r    = '{KIND_STATUS, STATUS_OK, '0, '0, '0, '0, 1'b1};
      case (it.op)
         OP_LOAD: begin
            n_loads++;
            src = int'(it.src);
            dst = int'(it.dst);
            if (src >= area || dst >= area || src >= PIXELS) begin
               r.status = STATUS_RANGE;
            end else if (fanout_seen.exists(src) && fanout_seen[src] >= MAX_FANOUT) begin
               r.status = STATUS_FULL;
            end else begin
               k = fanout_seen.exists(src) ? int'(fanout_seen[src]) : 0;
               dest_x_seen[src * MAX_FANOUT + k] = COORD_W'(dst % w);
               dest_y_seen[src * MAX_FANOUT + k] = COORD_W'(dst / w);
               fanout_seen[src] = CNT_W'(k + 1);
            end
            results_due = {results_due, r};
            cnt = 1;
         end
         OP_EVENT: begin
            n_events++;
            if (int'(it.x) < w && int'(it.y) < h) begin
               src = int'(it.y) * w + int'(it.x);
               if (src < PIXELS && fanout_seen.exists(src)) begin
                  cnt = int'(fanout_seen[src]);
                  for (k = 0; k < cnt; k++) begin
                     r.kind = KIND_EVENT;
                     r.x    = dest_x_seen[src * MAX_FANOUT + k];
                     r.y    = dest_y_seen[src * MAX_FANOUT + k];
                     r.ts   = it.ts;
                     r.pol  = it.pol;
                     r.last = (k == cnt - 1);
                     results_due = {results_due, r};
                  end
               end
            end
         end
         OP_CLEAR: begin
            n_clears++;
            fanout_seen.delete();
            results_due = {results_due, r};
            cnt = 1;
         end
         default: n_unused++;
      endcase
      return cnt;
   endfunction

   // item driver: presents the backlog head, idles in bursts
   always @(posedge clock) begin : item_driver
      logic taken;
      taken = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (taken) begin
            n_predicted <= n_predicted + remap_item(item_backlog[0]);
            n_accepted  <= n_accepted + 1;
            void'(item_backlog.pop_front());
         end
         if (req_tvalid && !taken) begin
            // keep the offered item until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (item_backlog.size() == 0 ||
                      (item_backlog[0].hold && (taken || n_predicted != n_checked))) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            gap_left   = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tuser  <= item_backlog[0].op;
            req_tdata  <= {4'b0, item_backlog[0].dst, item_backlog[0].src,
                           item_backlog[0].pol, item_backlog[0].ts,
                           item_backlog[0].y, item_backlog[0].x};
         end
      end
   end

   // result monitor: stalls in bursts, checks each transfer against the oldest due result
   always @(posedge clock) begin : result_checker
      remap_result_type got, want;
      logic bad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = kind_type'(rsp_tuser);
            got.status = status_type'(rsp_tdata[1:0]);
            got.x      = rsp_tdata[11:2];
            got.y      = rsp_tdata[21:12];
            got.ts     = rsp_tdata[53:22];
            got.pol    = rsp_tdata[85:54];
            got.last   = rsp_tlast;
            n_checked <= n_checked + 1;
            if (results_due.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("unexpected result: kind %0d status %0d x %0d y %0d",
                           got.kind, got.status, got.x, got.y,
                           " ts %h pol %h last %0d", got.ts, got.pol, got.last);
            end else begin
               want = results_due.pop_front();
               bad  = (got.kind !== want.kind) || (got.status !== want.status) ||
                      (got.x !== want.x) || (got.y !== want.y) || (got.ts !== want.ts) ||
                      (got.pol !== want.pol) || (got.last !== want.last);
               if (bad) begin
                  n_errors++;
                  if (n_errors <= 10) begin
                     $display("mismatch at %0t ns", $realtime);
                     $display("  expected kind %0d status %0d x %0d y %0d ts %h pol %h last %0d",
                              want.kind, want.status, want.x, want.y, want.ts, want.pol,
                              want.last);
                     $display("  actual   kind %0d status %0d x %0d y %0d ts %h pol %h last %0d",
                              got.kind, got.status, got.x, got.y, got.ts, got.pol, got.last);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic pixel_item_type rand_item(input logic [OP_W-1:0] op);
      pixel_item_type it;
      it.op   = op;
      it.x    = COORD_W'($urandom);
      it.y    = COORD_W'($urandom);
      it.ts   = $urandom;
      it.pol  = $urandom;
      it.src  = FLAT_W'($urandom);
      it.dst  = FLAT_W'($urandom);
      it.hold = 1'b0;
      return it;
   endfunction

   task automatic queue_item(input pixel_item_type it);
      item_backlog = {item_backlog, it};
      n_queued++;
   endtask

   task automatic queue_op(input logic [OP_W-1:0] op);
      queue_item(rand_item(op));
   endtask

   task automatic queue_load(input int src, input int dst);
      pixel_item_type it;
      it     = rand_item(OP_LOAD);
      it.src = FLAT_W'(src);
      it.dst = FLAT_W'(dst);
      queue_item(it);
   endtask

   task automatic queue_event(input int x, input int y, input logic [WORD_W-1:0] ts,
                              input logic [WORD_W-1:0] pol, input bit hold);
      pixel_item_type it;
      it      = rand_item(OP_EVENT);
      it.x    = COORD_W'(x);
      it.y    = COORD_W'(y);
      it.ts   = ts;
      it.pol  = pol;
      it.hold = hold;
      queue_item(it);
   endtask

   // register write transfer, mirrored into the shadow size
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WIDTH) shadow_width = val;
      else if (idx == REG_HEIGHT) shadow_height = val;
   endtask

   // wait until every item is taken and every result is in, then let the block go idle
   task automatic settle();
      @(posedge clock);
      while (!(n_accepted == n_queued && n_predicted == n_checked && req_tready))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // loads and events around a few source pixels, with some noise mixed in
   task automatic random_phase(input int count, input bit with_clear);
      int w, h, area, dst_top, ymax, pick, roll, k;
      int px [6];
      int py [6];
      w       = sensor_dim(shadow_width);
      h       = sensor_dim(shadow_height);
      area    = w * h;
      dst_top = ((area < PIXELS) ? area : PIXELS) - 1;
      ymax    = PIXELS / w - 1;
      if (ymax > h - 1) ymax = h - 1;
      for (k = 0; k < 6; k++) begin
         px[k] = $urandom_range(0, w - 1);
         py[k] = $urandom_range(0, ymax);
      end
      for (k = 0; k < count; k++) begin
         if (with_clear && k == count / 2) queue_op(OP_CLEAR);
         pick = $urandom_range(0, 5);
         roll = $urandom_range(0, 99);
         if (roll < 40)
            queue_load(py[pick] * w + px[pick], $urandom_range(0, dst_top));
         else if (roll < 80)
            queue_event(px[pick], py[pick], $urandom, $urandom, 1'b0);
         else if (roll < 88)
            queue_event($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom, $urandom, 1'b0);
         else if (roll < 95)
            queue_load($urandom_range(0, 65535), $urandom_range(0, 65535));
         else if (roll < 97)
            queue_op(OP_UNUSED);
         else
            queue_event(px[pick], py[pick], $urandom, $urandom, 1'b1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default 256 x 256 sensor: fill one source, overflow it, fan out, clear
      queue_op(OP_CLEAR);
      queue_load(0, 16'hFFFF);
      queue_load(0, 0);
      queue_load(0, 300);
      queue_load(0, 16'hFF00);
      queue_load(0, 1);
      queue_load(16'hFFFF, 0);
      queue_event(0, 0, '1, '0, 1'b0);
      queue_event(255, 255, '0, '1, 1'b0);
      queue_event(1, 0, $urandom, $urandom, 1'b0);
      queue_event(1023, 0, $urandom, $urandom, 1'b0);
      queue_event(0, 1023, $urandom, $urandom, 1'b0);
      queue_op(OP_UNUSED);
      queue_event(0, 0, $urandom, $urandom, 1'b1);
      queue_op(OP_CLEAR);
      queue_event(0, 0, $urandom, $urandom, 1'b0);
      random_phase(22, 1'b0);
      settle();

      // zero size clamps to a single pixel
      write_reg(REG_WIDTH, '0);
      write_reg(REG_HEIGHT, '0);
      @(negedge clock);
      queue_load(0, 0);
      queue_load(1, 0);
      queue_load(0, 1);
      queue_event(0, 0, $urandom, $urandom, 1'b0);
      queue_event(1, 0, $urandom, $urandom, 1'b0);
      random_phase(12, 1'b1);
      settle();

      // oversize clamps to 1024 x 1024, rows past 63 ravel beyond the table
      write_reg(REG_WIDTH, '1);
      write_reg(REG_HEIGHT, '1);
      @(negedge clock);
      queue_load(16'hFFFF, 16'hFFFF);
      queue_event(1023, 63, $urandom, $urandom, 1'b0);
      queue_event(1023, 64, $urandom, $urandom, 1'b0);
      random_phase(27, 1'b0);
      settle();

      // odd 100 x 7 sensor, spare register index, no idling from here on
      write_reg(REG_WIDTH, DIM_W'(100));
      write_reg(REG_HEIGHT, DIM_W'(7));
      write_reg(REG_SPARE, '1);
      @(negedge clock);
      quiet = 1'b1;
      queue_load(700, 0);
      queue_load(0, 700);
      queue_event(100, 0, $urandom, $urandom, 1'b0);
      queue_event(99, 6, $urandom, $urandom, 1'b0);
      random_phase(20, 1'b0);
      settle();

      $display("covered %0d loads, %0d events, %0d clears, %0d unused ops on four sensor sizes",
               n_loads, n_events, n_clears, n_unused);
      $display("checked %0d result transfers, %0d mismatches, %0d still due",
               n_checked, n_errors, results_due.size());
      if (n_errors == 0 && results_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- event_pixel_fanout_remapper_core.f -----
sv/epfr_pkg.sv
sv/epfr_divider.sv
sv/epfr_datapath.sv
sv/epfr_ctrl.sv
sv/event_pixel_fanout_remapper_core.sv
bench/tb_top.sv
